[rtl/fdmr_pkg.sv]
package fdmr_pkg;

    localparam int FRAME_PIXELS = 307200;
    localparam int ADDR_W       = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
    localparam int POS_W        = $clog2(FRAME_PIXELS + 1);

    localparam int PIX_W   = 8;
    localparam int LUMA_W  = 8;
    localparam int CNT_W   = 23;
    localparam int QUIET_W = 9;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;

    localparam int COEF_W  = 14;
    localparam int PROD_W  = PIX_W + COEF_W;
    localparam int SUM_W   = PROD_W;

    localparam logic [COEF_W-1:0] LUMA_R    = 14'd4899;
    localparam logic [COEF_W-1:0] LUMA_G    = 14'd9617;
    localparam logic [COEF_W-1:0] LUMA_B    = 14'd1868;
    localparam logic [SUM_W-1:0]  LUMA_HALF = 22'd8192;

    localparam logic [CNT_W-1:0]      CHANGED_MAX  = '1;
    localparam logic [QUIET_W-1:0]    QUIET_MAX    = '1;
    localparam logic [CFG_DATA_W-1:0] THRESH_RESET = 8'd25;
    localparam logic [CFG_DATA_W-1:0] LIMIT_RESET  = 8'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIFF_THRESHOLD    = 4'd0,
        REG_QUIET_FRAME_LIMIT = 4'd1
    } t_reg_idx;

    typedef struct packed {
        logic             compared;
        logic             motion;
        logic [CNT_W-1:0] changed_pixels;
        logic             write_frame;
        logic             start_recording;
        logic             stop_recording;
    } t_result;

endpackage

[rtl/fdmr_pix_if.sv]
interface fdmr_pix_if import fdmr_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             frame_end;

    modport source (output valid, red, green, blue, frame_end, input ready);
    modport sink   (input valid, red, green, blue, frame_end, output ready);
endinterface

[rtl/fdmr_res_if.sv]
interface fdmr_res_if import fdmr_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             compared;
    logic             motion;
    logic [CNT_W-1:0] changed_pixels;
    logic             write_frame;
    logic             start_recording;
    logic             stop_recording;

    modport source (output valid, compared, motion, changed_pixels, write_frame,
                    start_recording, stop_recording, input ready);
    modport sink   (input valid, compared, motion, changed_pixels, write_frame,
                    start_recording, stop_recording, output ready);
endinterface

[rtl/fdmr_cfg_if.sv]
interface fdmr_cfg_if import fdmr_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/frame_difference_motion_recorder_core.sv]
// channel   dir  handshake        payload
// i_pix     in   valid/ready      red, green, blue, frame_end
// o_res     out  valid/ready      compared, motion, changed_pixels, write_frame,
//                                 start_recording, stop_recording
// i_cfg     in   valid/ready      index, data (ready always high)
//
// one pixel per cycle unless an output result waits unaccepted; a frame_end pixel's result
// is registered with luma products and ram read, then with compare and frame decision
// the luma ram has one write and one read port; a same-address hit is forwarded
// synchronous active-low reset clears control state; the luma ram is not cleared
// i_pix.ready drops only while a result sits in the output register unaccepted
module frame_difference_motion_recorder_core import fdmr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fdmr_pix_if.sink  i_pix,
    fdmr_res_if.source o_res,
    fdmr_cfg_if.sink  i_cfg
);

    logic [CFG_DATA_W-1:0] r_thresh, n_thresh;
    logic [CFG_DATA_W-1:0] r_limit,  n_limit;

    logic [POS_W-1:0]  r_pos, n_pos;
    logic              r_have, n_have;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [QUIET_W-1:0] r_quiet, n_quiet;
    logic              r_rec, n_rec;

    logic              r_s1_valid;
    logic              r_s1_last;
    logic              r_s1_rng;
    logic [ADDR_W-1:0] r_s1_addr;
    logic              r_fwd;
    logic [LUMA_W-1:0] r_fwd_data;

    logic              r_out_valid, n_out_valid;
    t_result           r_out, n_out;

    logic              en;
    logic              acc;
    logic              in_rng;
    logic [ADDR_W-1:0] rd_addr;
    logic              we;
    logic [LUMA_W-1:0] luma;
    logic [LUMA_W-1:0] rdata;
    logic [LUMA_W-1:0] prev;
    logic [LUMA_W-1:0] diff;
    logic              chg;
    logic [CNT_W-1:0]  cnt_new;
    logic [QUIET_W-1:0] quiet_inc;

    assign en     = !r_out_valid || o_res.ready;
    assign acc    = i_pix.valid && en;
    assign in_rng = r_pos < POS_W'(FRAME_PIXELS);
    assign rd_addr = ADDR_W'(r_pos);
    assign we     = en && r_s1_valid && r_s1_rng;

    assign i_pix.ready = en;
    assign i_cfg.ready = 1'b1;

    fdmr_luma u_luma (
        .i_clk   (i_clk),
        .i_en    (acc),
        .i_red   (i_pix.red),
        .i_green (i_pix.green),
        .i_blue  (i_pix.blue),
        .o_luma  (luma)
    );

    fdmr_ram #(
        .WIDTH (LUMA_W),
        .DEPTH (FRAME_PIXELS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_s1_addr),
        .i_wdata (luma),
        .i_re    (acc),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    // compare and count
    assign prev      = r_fwd ? r_fwd_data : rdata;
    assign diff      = (luma > prev) ? (luma - prev) : (prev - luma);
    assign chg       = r_have && r_s1_rng && (diff > r_thresh) && (r_cnt != CHANGED_MAX);
    assign cnt_new   = r_cnt + CNT_W'(chg);
    assign quiet_inc = (r_quiet == QUIET_MAX) ? r_quiet : r_quiet + 1'b1;

    always_comb begin
        n_thresh = r_thresh;
        n_limit  = r_limit;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_DIFF_THRESHOLD:    n_thresh = i_cfg.data;
                REG_QUIET_FRAME_LIMIT: n_limit  = i_cfg.data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_pos = r_pos;
        if (acc) begin
            if (i_pix.frame_end) begin
                n_pos = '0;
            end else if (in_rng) begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    always_comb begin
        n_have      = r_have;
        n_cnt       = r_cnt;
        n_quiet     = r_quiet;
        n_rec       = r_rec;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (en) begin
            n_out_valid = r_s1_valid && r_s1_last;
            if (r_s1_valid) begin
                if (r_s1_last) begin
                    n_out = '0;
                    if (r_have) begin
                        n_out.compared       = 1'b1;
                        n_out.changed_pixels = cnt_new;
                        if (cnt_new != '0) begin
                            n_out.motion      = 1'b1;
                            n_out.write_frame = 1'b1;
                            n_quiet           = '0;
                            if (!r_rec) begin
                                n_out.start_recording = 1'b1;
                                n_rec                 = 1'b1;
                            end
                        end else begin
                            n_quiet = quiet_inc;
                            if (r_rec && (quiet_inc > QUIET_W'(r_limit))) begin
                                n_out.stop_recording = 1'b1;
                                n_rec                = 1'b0;
                            end
                        end
                    end
                    n_have = 1'b1;
                    n_cnt  = '0;
                end else begin
                    n_cnt = cnt_new;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh    <= THRESH_RESET;
            r_limit     <= LIMIT_RESET;
            r_pos       <= '0;
            r_have      <= 1'b0;
            r_cnt       <= '0;
            r_quiet     <= '0;
            r_rec       <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_thresh    <= n_thresh;
            r_limit     <= n_limit;
            r_pos       <= n_pos;
            r_have      <= n_have;
            r_cnt       <= n_cnt;
            r_quiet     <= n_quiet;
            r_rec       <= n_rec;
            r_out_valid <= n_out_valid;
            if (en) begin
                r_s1_valid <= acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (acc) begin
            r_s1_last  <= i_pix.frame_end;
            r_s1_rng   <= in_rng;
            r_s1_addr  <= rd_addr;
            r_fwd      <= we && (r_s1_addr == rd_addr);
            r_fwd_data <= luma;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.compared        = r_out.compared;
    assign o_res.motion          = r_out.motion;
    assign o_res.changed_pixels  = r_out.changed_pixels;
    assign o_res.write_frame     = r_out.write_frame;
    assign o_res.start_recording = r_out.start_recording;
    assign o_res.stop_recording  = r_out.stop_recording;

`ifndef NO_ASSERTIONS
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(FRAME_PIXELS))
        else $error("pixel position beyond frame size");

    a_motion_compared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.motion |-> r_out.compared && (r_out.changed_pixels != '0))
        else $error("motion reported without a compared frame");

    a_start_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.start_recording |-> r_out.write_frame && !r_out.stop_recording)
        else $error("inconsistent recording decision");

    a_rec_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_rec) |-> $rose(r_out_valid) || $past(en))
        else $error("recording began without a frame result");
`endif

endmodule

[rtl/fdmr_ram.sv]
module fdmr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/fdmr_luma.sv]
module fdmr_luma import fdmr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [PIX_W-1:0]  i_red,
    input  logic [PIX_W-1:0]  i_green,
    input  logic [PIX_W-1:0]  i_blue,
    output logic [LUMA_W-1:0] o_luma
);

    logic [PROD_W-1:0] r_prod_r;
    logic [PROD_W-1:0] r_prod_g;
    logic [PROD_W-1:0] r_prod_b;
    logic [SUM_W-1:0]  sum;

    // weights swapped back to red/green/blue order
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod_r <= PROD_W'(i_red)   * PROD_W'(LUMA_R);
            r_prod_g <= PROD_W'(i_green) * PROD_W'(LUMA_G);
            r_prod_b <= PROD_W'(i_blue)  * PROD_W'(LUMA_B);
        end
    end

    assign sum    = r_prod_r + r_prod_g + r_prod_b + LUMA_HALF;
    assign o_luma = sum[SUM_W-1 -: LUMA_W];

endmodule
